[rtl/svs_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svs_pkg: shared types and constants of the sprite quad vertex setup
// codes, widths, vertex order tables and the sine phase function
// ---------------------------------------------------------------------------
package svs_pkg;

   localparam int COORD_W = 28;   // pixel coordinates, signed q.8
   localparam int NUM_W   = 40;   // divider numerator
   localparam int VIEW_W  = 13;
   localparam int DEN_W   = 14;
   localparam int SIN_W   = 18;   // signed q.16, 1.0 = 65536
   localparam int PROD_W  = 46;

   localparam logic [VIEW_W-1:0] VIEW_WIDTH_RESET  = 13'd640;
   localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RESET = 13'd480;

   // register index decoded from paddr[2]
   localparam logic CSR_VIEW_WIDTH  = 1'b0;
   localparam logic CSR_VIEW_HEIGHT = 1'b1;

   localparam logic KIND_SPRITE = 1'b0;
   localparam logic KIND_RECT   = 1'b1;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   function automatic logic [2:0] quad_corner(input logic [2:0] k);
      logic [2:0] c;
      case (k)
         3'd0:    c = 3'd0;
         3'd1:    c = 3'd3;
         3'd2:    c = 3'd2;
         3'd3:    c = 3'd0;
         3'd4:    c = 3'd2;
         3'd5:    c = 3'd1;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] hollow_corner(input logic [4:0] k);
      logic [2:0] c;
      case (k)
         5'd0:  c = 3'd0;  5'd1:  c = 3'd4;  5'd2:  c = 3'd5;
         5'd3:  c = 3'd0;  5'd4:  c = 3'd5;  5'd5:  c = 3'd1;
         5'd6:  c = 3'd3;  5'd7:  c = 3'd2;  5'd8:  c = 3'd6;
         5'd9:  c = 3'd3;  5'd10: c = 3'd6;  5'd11: c = 3'd7;
         5'd12: c = 3'd0;  5'd13: c = 3'd3;  5'd14: c = 3'd7;
         5'd15: c = 3'd0;  5'd16: c = 3'd7;  5'd17: c = 3'd4;
         5'd18: c = 3'd5;  5'd19: c = 3'd6;  5'd20: c = 3'd2;
         5'd21: c = 3'd5;  5'd22: c = 3'd2;  5'd23: c = 3'd1;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   // sine of a 16-bit phase, taylor series to x^13 in q30, rounded to q.16
   function automatic logic signed [SIN_W-1:0] sine_of_phase(input longint unsigned a);
      longint unsigned q, r, x, x2, sum, term;
      logic signed [SIN_W-1:0] v;
      q = (a >> 14) & 64'd3;
      r = a & 64'd16383;
      if (q[0]) r = 64'd16384 - r;
      x = (r * HALF_PI_Q30) >> 14;
      x2 = (x * x) >> 30;
      sum = x;
      term = x;
      term = ((term * x2) >> 30) / 6;   sum = sum - term;
      term = ((term * x2) >> 30) / 20;  sum = sum + term;
      term = ((term * x2) >> 30) / 42;  sum = sum - term;
      term = ((term * x2) >> 30) / 72;  sum = sum + term;
      term = ((term * x2) >> 30) / 110; sum = sum - term;
      term = ((term * x2) >> 30) / 156; sum = sum + term;
      v = SIN_W'((sum + 64'd8192) >> 14);
      return (q >= 64'd2) ? -v : v;
   endfunction

endpackage

[rtl/svs_sine_rom.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svs_sine_rom: sine lookup table
// constant table built at elaboration, registered read
// ---------------------------------------------------------------------------
module svs_sine_rom #(
   parameter int DEPTH = 1024,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                                 clock,
   input  logic [IDX_W-1:0]                     rd_addr,
   output logic signed [svs_pkg::SIN_W-1:0]     rd_data_ff
);

   typedef logic signed [svs_pkg::SIN_W-1:0] tab_type [DEPTH];

   function automatic tab_type build_tab();
      tab_type t;
      for (int i = 0; i < DEPTH; i++) begin
         t[i] = svs_pkg::sine_of_phase((longint'(i) * 65536) / DEPTH);
      end
      return t;
   endfunction

   localparam tab_type SINE_TAB = build_tab();

   always_ff @(posedge clock) begin
      rd_data_ff <= SINE_TAB[rd_addr];
   end

endmodule

[rtl/svs_mul.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svs_mul: shared signed multiplier
// one product per cycle, result registered
// ---------------------------------------------------------------------------
module svs_mul (
   input  logic                                  clock,
   input  logic signed [svs_pkg::SIN_W-1:0]      op_a,
   input  logic signed [svs_pkg::COORD_W-1:0]    op_b,
   output logic signed [svs_pkg::PROD_W-1:0]     prod_ff
);

   // operands sign extended to the full product width
   always_ff @(posedge clock) begin
      prod_ff <= svs_pkg::PROD_W'(op_a) * svs_pkg::PROD_W'(op_b);
   end

endmodule

[rtl/svs_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svs_div: iterative floor divider
// restoring division, one quotient bit per cycle, signed numerator
// ---------------------------------------------------------------------------
module svs_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [svs_pkg::NUM_W-1:0]     num,
   input  logic [svs_pkg::DEN_W-1:0]            den,
   output logic                                 done_ff,
   output logic signed [svs_pkg::NUM_W-1:0]     quo_ff
);

   localparam int NW = svs_pkg::NUM_W;
   localparam int DW = svs_pkg::DEN_W;

   logic            busy_ff, busy_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [NW-1:0]   mag_ff, mag_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic            neg_ff, neg_in;
   logic            done_in;
   logic signed [NW-1:0] quo_in;
   logic [DW:0]     trial;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, mag_ff[NW-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(NW);
         neg_in  = num[NW-1];
         mag_in  = num[NW-1] ? NW'(-num) : NW'(num);
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         mag_in = {mag_ff[NW-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // floor for negative numerators: round the magnitude up
            quo_in  = neg_ff ? -(signed'(mag_in) + NW'(rem_in != '0)) : signed'(mag_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

endmodule

[rtl/sprite_quad_vertex_setup_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_quad_vertex_setup_unit: draw object to triangle vertex setup
// turns one sprite or rectangle into 6 or 24 ndc vertices with batch flags
// ---------------------------------------------------------------------------
// One object is taken at a time. A sprite gives 6 vertices of an unrotated
// quad with its uv corners; a rectangle has its corners rotated about the
// pivot (sine/cosine from a table of SINE_TABLE_DEPTH entries) and gives 6
// vertices, or 24 border vertices with a 2 pixel inset when hollow and both
// sides are wider than 4 pixels. The pivot, rotation and ndc arithmetic runs
// through one shared multiplier and one iterative divider that gives one
// quotient bit a cycle. Each ndc coordinate is one divide: a start, the 40
// quotient bits and the result pick-up. A rectangle corner also has its four
// rotation multiplies, and rectangles first work out the pivot and make the
// two table reads. After the corners, vertex beats leave one per cycle while
// rsp_tready stays high. req_tready is low from the accepted beat until the
// last vertex beat is loaded into the output register; the next object may
// be accepted while that beat still waits on rsp_tready. Viewport registers sit
// at byte 0 (width) and byte 4 (height); a value of zero is treated as one.
// Write them only while the block is idle.
// ---------------------------------------------------------------------------
module sprite_quad_vertex_setup_unit #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic          clock,
   input  logic          reset,
   // object beats
   input  logic          req_tvalid,
   output logic          req_tready,
   // pos_x[23:0] pos_y[47:24] size_w[59:48] size_h[71:60] tex_id[87:72]
   // tex_rect[151:88] rgba_color[183:152] filled[184] angle[200:185]
   // pivot[232:201], zero padded
   input  logic [239:0]  req_tdata,
   // frame_start[0] obj_kind[1]
   input  logic [1:0]    req_tuser,
   // vertex beats
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // vert_x[23:0] vert_y[47:24] tex_u[63:48] tex_v[79:64]
   output logic [79:0]   rsp_tdata,
   // new_batch[0]
   output logic          rsp_tuser,
   output logic          rsp_tlast,
   // configuration
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int CW    = svs_pkg::COORD_W;
   localparam int NW    = svs_pkg::NUM_W;
   localparam int SW    = svs_pkg::SIN_W;
   localparam int PW    = svs_pkg::PROD_W;
   localparam int VW    = svs_pkg::VIEW_W;
   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE, S_PIVX, S_PIVXW, S_PIVY, S_PIVYW, S_SIN, S_COS, S_COSW,
      S_CORNER, S_M2, S_M3, S_M4, S_M5, S_DX, S_DXW, S_DY, S_DYW, S_EMIT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [VW-1:0] view_w_ff, view_h_ff;
   logic          csr_wr;

   // batch tracking
   logic          batch_open_ff, batch_kind_ff, batch_filled_ff;
   logic [15:0]   batch_tex_ff;
   logic [31:0]   batch_color_ff;
   logic          nb_in, nb_ff;

   // object fields
   logic                 kind_ff, hollow_ff;
   logic signed [CW-1:0] sx_ff, sy_ff;
   logic [11:0]          w_ff, h_ff;
   logic [63:0]          trect_ff;
   logic [15:0]          ang_ff;
   logic [31:0]          piv_ff;
   logic                 req_accept;

   // datapath registers
   logic signed [CW-1:0] pvx_ff, pvy_ff, rx_ff, ry_ff;
   logic signed [SW-1:0] sin_ff, cos_ff;
   logic signed [PW:0]   acc_ff;
   logic [2:0]           corner_ff;
   logic [23:0]          nx_ff [8];
   logic [23:0]          ny_ff [8];
   logic [4:0]           k_ff;

   // shared units
   logic signed [SW-1:0] mul_a;
   logic signed [CW-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   logic                 div_start, div_done;
   logic signed [NW-1:0] div_num, div_quo;
   logic [svs_pkg::DEN_W-1:0] div_den;
   logic [IDX_W-1:0]     rom_addr;
   logic signed [SW-1:0] rom_data;

   // per-corner combinational values
   logic signed [CW-1:0] cx, cy, dx, dy, ox, oy;
   logic [19:0]          ws, hs;
   logic [31:0]          si_prod, ci_prod;
   logic [15:0]          ci_ang;
   logic [VW-1:0]        vw_eff, vh_eff;
   logic signed [PW:0]   rot_x, rot_y;
   logic signed [CW-1:0] px_sel;
   logic [2:0]           out_corner;
   logic [2:0]           last_corner;
   logic [4:0]           last_k;
   logic                 rsp_load;
   logic                 rsp_tvalid_ff, rsp_tuser_ff, rsp_tlast_ff;
   logic [79:0]          rsp_tdata_ff;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == svs_pkg::CSR_VIEW_HEIGHT) ?
                       {19'd0, view_h_ff} : {19'd0, view_w_ff};

   assign vw_eff = (view_w_ff == '0) ? VW'(1) : view_w_ff;
   assign vh_eff = (view_h_ff == '0) ? VW'(1) : view_h_ff;

   // ---------------------------------------------------------------------
   // batch decision, taken on the accepted object beat
   // ---------------------------------------------------------------------
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      nb_in = req_tuser[0] || !batch_open_ff || (req_tuser[1] != batch_kind_ff);
      if (!nb_in) begin
         if (req_tuser[1] == svs_pkg::KIND_SPRITE) begin
            nb_in = req_tdata[87:72] != batch_tex_ff;
         end else begin
            nb_in = (req_tdata[183:152] != batch_color_ff) ||
                    (req_tdata[184] != batch_filled_ff);
         end
      end
   end

   // ---------------------------------------------------------------------
   // corner geometry: 0..3 outer corners, 4..7 inset by 2 pixels
   // ---------------------------------------------------------------------
   assign ws = {w_ff, 8'd0};
   assign hs = {h_ff, 8'd0};

   always_comb begin
      case (corner_ff)
         3'd1, 3'd2: ox = CW'(ws);
         3'd4, 3'd7: ox = CW'(512);
         3'd5, 3'd6: ox = CW'(ws) - CW'(512);
         default:    ox = '0;
      endcase
      case (corner_ff)
         3'd2, 3'd3: oy = CW'(hs);
         3'd4, 3'd5: oy = CW'(512);
         3'd6, 3'd7: oy = CW'(hs) - CW'(512);
         default:    oy = '0;
      endcase
   end

   assign cx = sx_ff + ox;
   assign cy = sy_ff + oy;
   assign dx = cx - pvx_ff;
   assign dy = cy - pvy_ff;

   // rotated offsets, rounded half up at 2^16
   assign rot_x = acc_ff - (PW+1)'(mul_p) + (PW+1)'(32768);
   assign rot_y = acc_ff + (PW+1)'(mul_p) + (PW+1)'(32768);

   // sine table indices; the cosine index is the sine index of the phase
   // advanced by a quarter turn
   assign ci_ang   = ang_ff + 16'd16384;
   assign si_prod  = 32'(ang_ff) * 32'(SINE_TABLE_DEPTH);
   assign ci_prod  = 32'(ci_ang) * 32'(SINE_TABLE_DEPTH);
   assign rom_addr = (state_ff == S_SIN) ? si_prod[16 +: IDX_W] : ci_prod[16 +: IDX_W];

   // ---------------------------------------------------------------------
   // shared multiplier operand select
   // ---------------------------------------------------------------------
   always_comb begin
      mul_a = cos_ff;
      mul_b = dx;
      case (state_ff)
         S_PIVX: begin
            mul_a = SW'(piv_ff[15:0]);
            mul_b = CW'(w_ff);
         end
         S_PIVY: begin
            mul_a = SW'(piv_ff[31:16]);
            mul_b = CW'(h_ff);
         end
         S_M2: begin
            mul_a = sin_ff;
            mul_b = dy;
         end
         S_M3: begin
            mul_a = sin_ff;
            mul_b = dx;
         end
         S_M4: begin
            mul_a = cos_ff;
            mul_b = dy;
         end
         default: begin
            mul_a = cos_ff;
            mul_b = dx;
         end
      endcase
   end

   // divider: n = px * 1024 + view, d = 2 * view, a half-up rounded px * 512 / view
   assign div_start = (state_ff == S_DX) || (state_ff == S_DY);
   assign px_sel    = (state_ff == S_DY) ? ry_ff : rx_ff;
   assign div_den   = (state_ff == S_DY) ? {vh_eff, 1'b0} : {vw_eff, 1'b0};
   assign div_num   = (NW'(px_sel) <<< 10) + NW'((state_ff == S_DY) ? vh_eff : vw_eff);

   function automatic logic [23:0] sat24(input logic signed [NW:0] v);
      if (v > (NW+1)'(8388607)) return 24'h7FFFFF;
      if (v < -(NW+1)'(8388608)) return 24'h800000;
      return v[23:0];
   endfunction

   // ---------------------------------------------------------------------
   // vertex emission
   // ---------------------------------------------------------------------
   assign last_corner = hollow_ff ? 3'd7 : 3'd3;
   assign last_k      = hollow_ff ? 5'd23 : 5'd5;
   assign out_corner  = hollow_ff ? svs_pkg::hollow_corner(k_ff)
                                  : svs_pkg::quad_corner(k_ff[2:0]);
   assign rsp_load    = (state_ff == S_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         view_w_ff       <= svs_pkg::VIEW_WIDTH_RESET;
         view_h_ff       <= svs_pkg::VIEW_HEIGHT_RESET;
         batch_open_ff   <= 1'b0;
         batch_kind_ff   <= 1'b0;
         batch_tex_ff    <= '0;
         batch_color_ff  <= '0;
         batch_filled_ff <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
         corner_ff       <= '0;
         k_ff            <= '0;
      end else begin
         if (csr_wr) begin
            if (csr_paddr[2] == svs_pkg::CSR_VIEW_HEIGHT) begin
               view_h_ff <= csr_pwdata[VW-1:0];
            end else begin
               view_w_ff <= csr_pwdata[VW-1:0];
            end
         end
         // output register: loaded from the emit state, emptied on a taken beat
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  sx_ff    <= CW'(signed'(req_tdata[23:0]));
                  sy_ff    <= CW'(signed'(req_tdata[47:24]));
                  w_ff     <= req_tdata[59:48];
                  h_ff     <= req_tdata[71:60];
                  trect_ff <= req_tdata[151:88];
                  ang_ff   <= req_tdata[200:185];
                  piv_ff   <= req_tdata[232:201];
                  kind_ff  <= req_tuser[1];
                  hollow_ff <= (req_tuser[1] == svs_pkg::KIND_RECT) && !req_tdata[184]
                               && (req_tdata[59:48] > 12'd4) && (req_tdata[71:60] > 12'd4);
                  nb_ff     <= nb_in;
                  corner_ff <= '0;
                  k_ff      <= '0;
                  if (nb_in) begin
                     batch_open_ff   <= 1'b1;
                     batch_kind_ff   <= req_tuser[1];
                     batch_tex_ff    <= (req_tuser[1] == svs_pkg::KIND_SPRITE) ?
                                        req_tdata[87:72] : 16'd0;
                     batch_color_ff  <= (req_tuser[1] == svs_pkg::KIND_RECT) ?
                                        req_tdata[183:152] : 32'd0;
                     batch_filled_ff <= (req_tuser[1] == svs_pkg::KIND_RECT) && req_tdata[184];
                  end
                  state_ff <= (req_tuser[1] == svs_pkg::KIND_RECT) ? S_PIVX : S_CORNER;
               end
            end
            S_PIVX:  state_ff <= S_PIVXW;
            S_PIVXW: begin
               pvx_ff   <= sx_ff + CW'(mul_p >>> 7);
               state_ff <= S_PIVY;
            end
            S_PIVY:  state_ff <= S_PIVYW;
            S_PIVYW: begin
               pvy_ff   <= sy_ff + CW'(mul_p >>> 7);
               state_ff <= S_SIN;
            end
            S_SIN:   state_ff <= S_COS;
            S_COS: begin
               sin_ff   <= rom_data;
               state_ff <= S_COSW;
            end
            S_COSW: begin
               cos_ff   <= rom_data;
               state_ff <= S_CORNER;
            end
            S_CORNER: begin
               if (kind_ff == svs_pkg::KIND_SPRITE) begin
                  rx_ff    <= cx;
                  ry_ff    <= cy;
                  state_ff <= S_DX;
               end else begin
                  state_ff <= S_M2;
               end
            end
            S_M2: begin
               acc_ff   <= (PW+1)'(mul_p);
               state_ff <= S_M3;
            end
            S_M3: begin
               rx_ff    <= pvx_ff + CW'(rot_x >>> 16);
               state_ff <= S_M4;
            end
            S_M4: begin
               acc_ff   <= (PW+1)'(mul_p);
               state_ff <= S_M5;
            end
            S_M5: begin
               ry_ff    <= pvy_ff + CW'(rot_y >>> 16);
               state_ff <= S_DX;
            end
            S_DX:  state_ff <= S_DXW;
            S_DXW: begin
               if (div_done) begin
                  nx_ff[corner_ff] <= sat24((NW+1)'(div_quo) - (NW+1)'(65536));
                  state_ff <= S_DY;
               end
            end
            S_DY:  state_ff <= S_DYW;
            S_DYW: begin
               if (div_done) begin
                  ny_ff[corner_ff] <= sat24((NW+1)'(65536) - (NW+1)'(div_quo));
                  corner_ff <= corner_ff + 3'd1;
                  state_ff  <= (corner_ff == last_corner) ? S_EMIT : S_CORNER;
               end
            end
            S_EMIT: begin
               if (rsp_load) begin
                  rsp_tuser_ff  <= nb_ff && (k_ff == '0);
                  rsp_tlast_ff  <= (k_ff == last_k);
                  if (kind_ff == svs_pkg::KIND_SPRITE) begin
                     rsp_tdata_ff <= {
                        (out_corner >= 3'd2) ? trect_ff[63:48] : trect_ff[31:16],
                        (out_corner == 3'd1 || out_corner == 3'd2) ?
                           trect_ff[47:32] : trect_ff[15:0],
                        ny_ff[out_corner], nx_ff[out_corner]};
                  end else begin
                     rsp_tdata_ff <= {32'd0, ny_ff[out_corner], nx_ff[out_corner]};
                  end
                  k_ff <= k_ff + 5'd1;
                  if (k_ff == last_k) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   svs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   svs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (div_den),
      .done_ff (div_done),
      .quo_ff  (div_quo)
   );

   svs_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH)
   ) u_rom (
      .clock      (clock),
      .rd_addr    (rom_addr),
      .rd_data_ff (rom_data)
   );

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("object accepted while previous object still in flight");

   a_last_ends_object: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (k_ff == last_k) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after last vertex");

   a_no_emit_past_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (k_ff <= last_k))
      else $error("vertex counter ran past vertex count");

   a_div_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DXW || state_ff == S_DYW))
      else $error("divider result arrived outside a wait state");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: sprite quad vertex setup unit
// drives sprite and rectangle objects under random bursts and output stalls,
// predicts every vertex beat in the bench and compares them field by field
// ---------------------------------------------------------------------------
module testbench;

   localparam int TAB_DEPTH    = 1024;
   localparam int WATCHDOG     = 20000;
   localparam int DRAIN_WAIT   = 20;
   localparam int HOLD_OFF_LEN = 3000;
   localparam logic [2:0] ADDR_VIEW_WIDTH  = 3'd0;
   localparam logic [2:0] ADDR_VIEW_HEIGHT = 3'd4;

   typedef struct packed {
      logic        frame_start;
      logic        obj_kind;
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [11:0] size_w;
      logic [11:0] size_h;
      logic [15:0] tex_id;
      logic [63:0] tex_rect;
      logic [31:0] rgba_color;
      logic        filled;
      logic [15:0] angle;
      logic [31:0] pivot;
   } draw_obj_type;

   typedef struct packed {
      logic        new_batch;
      logic [23:0] vert_x;
      logic [23:0] vert_y;
      logic [15:0] tex_u;
      logic [15:0] tex_v;
      logic        last_vertex;
   } vertex_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [239:0]  req_tdata;    // pos_x pos_y size_w size_h tex_id tex_rect colour filled angle pivot
   logic [1:0]    req_tuser;    // frame_start obj_kind
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [79:0]   rsp_tdata;    // vert_x vert_y tex_u tex_v
   logic          rsp_tuser;    // new_batch
   logic          rsp_tlast;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [2:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   sprite_quad_vertex_setup_unit #(.SINE_TABLE_DEPTH(TAB_DEPTH)) u_top (.*);

   // bench copy of viewport, batch tracking and sine table
   logic [12:0]    cur_view_w, cur_view_h;
   logic           trk_open, trk_kind, trk_filled;
   logic [15:0]    trk_tex;
   logic [31:0]    trk_color;
   longint         sine_lut [TAB_DEPTH];
   vertex_type     expected_verts[$];
   int             fail_count = 0;
   int             idle_cycles = 0;
   bit             hold_off_tgl = 1'b0;
   bit             hold_seen;
   int             hold_left;
   int             burst_left = 0;

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic longint lut_sine(input longint unsigned a);
      longint unsigned q, r, x, x2, sum, term;
      longint v;
      q = (a >> 14) & 3;
      r = a & 16383;
      if (q[0]) r = 16384 - r;
      x = (r * 64'd1686629713) >> 14;
      x2 = (x * x) >> 30;
      sum = x;
      term = x;
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n % 2) sum = sum - term;
         else sum = sum + term;
      end
      v = longint'((sum + 8192) >> 14);
      return (q >= 2) ? -v : v;
   endfunction

   function automatic longint fdiv(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp_ndc(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint to_ndc_x(input longint px);
      longint vw;
      vw = (cur_view_w == 0) ? 1 : longint'(cur_view_w);
      return clamp_ndc(fdiv(2 * px * 512 + vw, 2 * vw) - 65536);
   endfunction

   function automatic longint to_ndc_y(input longint py);
      longint vh;
      vh = (cur_view_h == 0) ? 1 : longint'(cur_view_h);
      return clamp_ndc(65536 - fdiv(2 * py * 512 + vh, 2 * vh));
   endfunction

   // works out all vertices of one object and queues them
   task automatic predict_vertices(input draw_obj_type o);
      logic           opens;
      longint         sx, sy, w, h, ws, hs, pvx, pvy, s, c, dx, dy, rx, ry;
      longint         cx[8], cy[8], nx[8], ny[8];
      int             nv, p, si, ci;
      bit             hollow;
      vertex_type     v;
      opens = o.frame_start || !trk_open || o.obj_kind != trk_kind;
      if (!opens) begin
         if (o.obj_kind == svs_pkg::KIND_SPRITE) opens = o.tex_id != trk_tex;
         else opens = o.rgba_color != trk_color || o.filled != trk_filled;
      end
      if (opens) begin
         trk_open   = 1'b1;
         trk_kind   = o.obj_kind;
         trk_tex    = (o.obj_kind == svs_pkg::KIND_SPRITE) ? o.tex_id : 16'd0;
         trk_color  = (o.obj_kind == svs_pkg::KIND_RECT) ? o.rgba_color : 32'd0;
         trk_filled = (o.obj_kind == svs_pkg::KIND_RECT) ? o.filled : 1'b0;
      end
      sx = longint'($signed(o.pos_x));
      sy = longint'($signed(o.pos_y));
      w = o.size_w;
      h = o.size_h;
      ws = w * 256;
      hs = h * 256;
      cx[0] = sx;      cy[0] = sy;
      cx[1] = sx + ws; cy[1] = sy;
      cx[2] = sx + ws; cy[2] = sy + hs;
      cx[3] = sx;      cy[3] = sy + hs;
      cx[4] = sx + 512;      cy[4] = sy + 512;
      cx[5] = sx + ws - 512; cy[5] = sy + 512;
      cx[6] = sx + ws - 512; cy[6] = sy + hs - 512;
      cx[7] = sx + 512;      cy[7] = sy + hs - 512;
      hollow = 1'b0;
      if (o.obj_kind == svs_pkg::KIND_SPRITE) begin
         for (int i = 0; i < 4; i++) begin
            nx[i] = to_ndc_x(cx[i]);
            ny[i] = to_ndc_y(cy[i]);
         end
      end else begin
         hollow = !o.filled && w > 4 && h > 4;
         pvx = sx + ((longint'(o.pivot[15:0]) * w) >>> 7);
         pvy = sy + ((longint'(o.pivot[31:16]) * h) >>> 7);
         si = (int'(o.angle) * TAB_DEPTH) >> 16;
         ci = (int'(16'(o.angle + 16'd16384)) * TAB_DEPTH) >> 16;
         s = sine_lut[si];
         c = sine_lut[ci];
         for (int i = 0; i < 8; i++) begin
            dx = cx[i] - pvx;
            dy = cy[i] - pvy;
            rx = pvx + fdiv(c * dx - s * dy + 32768, 65536);
            ry = pvy + fdiv(s * dx + c * dy + 32768, 65536);
            nx[i] = to_ndc_x(rx);
            ny[i] = to_ndc_y(ry);
         end
      end
      nv = hollow ? 24 : 6;
      for (int k = 0; k < nv; k++) begin
         p = hollow ? int'(svs_pkg::hollow_corner(5'(k))) : int'(svs_pkg::quad_corner(3'(k)));
         v.new_batch   = opens && k == 0;
         v.vert_x      = 24'(nx[p]);
         v.vert_y      = 24'(ny[p]);
         v.tex_u       = 16'd0;
         v.tex_v       = 16'd0;
         if (o.obj_kind == svs_pkg::KIND_SPRITE) begin
            v.tex_u = (p == 1 || p == 2) ? o.tex_rect[47:32] : o.tex_rect[15:0];
            v.tex_v = (p >= 2) ? o.tex_rect[63:48] : o.tex_rect[31:16];
         end
         v.last_vertex = (k == nv - 1);
         expected_verts.push_back(v);
      end
   endtask

   // sends one object, bursts of beats separated by random gaps;
   // tvalid stays up after a beat until the next beat or a pause
   task automatic send_object(input draw_obj_type o);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 40)) : 0;
         burst_left = $urandom_range(1, 8);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left = burst_left - 1;
      req_tdata  <= {7'd0, o.pivot, o.angle, o.filled, o.rgba_color, o.tex_rect, o.tex_id,
                     o.size_h, o.size_w, o.pos_y, o.pos_x};
      req_tuser  <= {o.obj_kind, o.frame_start};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_vertices(o);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_verts.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      if (addr == ADDR_VIEW_WIDTH) cur_view_w = data[12:0];
      else cur_view_h = data[12:0];
   endtask

   task automatic set_viewport(input logic [12:0] vw, input logic [12:0] vh);
      wait_drained();
      csr_write(ADDR_VIEW_WIDTH, {19'd0, vw});
      csr_write(ADDR_VIEW_HEIGHT, {19'd0, vh});
   endtask

   function automatic draw_obj_type random_object(input bit rect);
      draw_obj_type o;
      o.frame_start = ($urandom_range(0, 15) == 0);
      o.obj_kind    = rect;
      o.pos_x       = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2048 * 256));
      o.pos_y       = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2048 * 256));
      o.size_w      = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(0, 64));
      o.size_h      = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(0, 64));
      // a small texture set so batches often continue
      o.tex_id      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
      o.tex_rect    = {$urandom, $urandom};
      o.rgba_color  = ($urandom_range(0, 3) == 0) ? $urandom : {30'd0, 2'($urandom)};
      o.filled      = 1'($urandom_range(0, 1));
      o.angle       = 16'($urandom);
      o.pivot       = $urandom;
      return o;
   endfunction

   task automatic test_sprite_extremes();
      draw_obj_type o;
      o = '0;
      o.frame_start = 1'b1;
      o.size_w = 12'd4095; o.size_h = 12'd4095;
      o.pos_x = 24'h7FFFFF; o.pos_y = 24'h800000;
      o.tex_rect = 64'h8000_8000_0000_0000;
      send_object(o);
      o.frame_start = 1'b0;
      o.pos_x = 24'h800000; o.pos_y = 24'h7FFFFF;
      o.tex_rect = 64'hFFFF_FFFF_FFFF_FFFF;
      o.tex_id = 16'hFFFF;
      o.angle = 16'hFFFF; o.pivot = '1; o.rgba_color = '1; o.filled = 1'b1;
      send_object(o);
      o.size_w = 12'd0; o.size_h = 12'd0;
      send_object(o);   // same texture, batch goes on
   endtask

   task automatic test_rect_shapes();
      draw_obj_type o;
      o = '0;
      o.obj_kind = svs_pkg::KIND_RECT;
      o.pos_x = 24'd25600; o.pos_y = 24'd12800;
      o.size_w = 12'd100; o.size_h = 12'd50;
      o.filled = 1'b1;
      send_object(o);                                   // angle zero, unrotated
      o.filled = 1'b0;
      send_object(o);                                   // hollow border
      o.size_w = 12'd4;
      send_object(o);                                   // thin hollow drawn solid
      o.size_w = 12'd5; o.size_h = 12'd4;
      send_object(o);
      o.size_h = 12'd5; o.angle = 16'd16384; o.pivot = 32'h4000_4000;
      send_object(o);
      o.angle = 16'h8000; o.pivot = 32'hFFFF_FFFF; o.rgba_color = 32'hFFFF_FFFF;
      send_object(o);
      o.angle = 16'hFFFF; o.size_w = 12'd4095; o.size_h = 12'd4095;
      o.pos_x = 24'h800000; o.pos_y = 24'h7FFFFF;
      send_object(o);
      o.obj_kind = svs_pkg::KIND_SPRITE;
      send_object(o);                                   // kind change
   endtask

   task automatic test_viewport_extremes();
      draw_obj_type o;
      o = random_object(1'b1);
      set_viewport(13'd0, 13'd0);                       // zero treated as one
      send_object(o);
      send_object(random_object(1'b0));
      set_viewport(13'd4096, 13'd1);
      send_object(o);
      set_viewport(13'h1FFF, 13'd4096);
      send_object(random_object(1'b0));
      set_viewport(13'd1, 13'h1FFF);
      send_object(random_object(1'b1));
   endtask

   task automatic test_random_objects(input int count);
      for (int i = 0; i < count; i++) begin
         send_object(random_object(1'($urandom_range(0, 1))));
         if (i % 40 == 39) set_viewport(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      end
   endtask

   task automatic test_output_hold_off();
      wait_drained();
      hold_off_tgl = ~hold_off_tgl;
      for (int i = 0; i < 6; i++) send_object(random_object(1'b1));
      wait_drained();                                   // sender pauses for the drain
   endtask

   // receiver stalls: a pattern of its own, plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen  <= hold_off_tgl;
         hold_left  <= 0;
      end else if (hold_off_tgl != hold_seen) begin
         hold_seen  <= hold_off_tgl;
         hold_left  <= HOLD_OFF_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // checks each vertex beat against the oldest prediction
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verts.size() == 0) begin
            $error("vertex beat with nothing expected");
            fail_count++;
         end else begin
            want = expected_verts.pop_front();
            if (rsp_tuser !== want.new_batch) begin
               $error("new_batch exp %0d got %0d", want.new_batch, rsp_tuser); fail_count++;
            end
            if (rsp_tdata[23:0] !== want.vert_x) begin
               $error("vert_x exp %h got %h", want.vert_x, rsp_tdata[23:0]); fail_count++;
            end
            if (rsp_tdata[47:24] !== want.vert_y) begin
               $error("vert_y exp %h got %h", want.vert_y, rsp_tdata[47:24]); fail_count++;
            end
            if (rsp_tdata[63:48] !== want.tex_u) begin
               $error("tex_u exp %h got %h", want.tex_u, rsp_tdata[63:48]); fail_count++;
            end
            if (rsp_tdata[79:64] !== want.tex_v) begin
               $error("tex_v exp %h got %h", want.tex_v, rsp_tdata[79:64]); fail_count++;
            end
            if (rsp_tlast !== want.last_vertex) begin
               $error("last_vertex exp %0d got %0d", want.last_vertex, rsp_tlast); fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat moved
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("[sprite_quad_vertex_setup_unit] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      cur_view_w = 13'd640; cur_view_h = 13'd480;
      trk_open = 0; trk_kind = 0; trk_filled = 0; trk_tex = '0; trk_color = '0;
      for (int i = 0; i < TAB_DEPTH; i++) sine_lut[i] = lut_sine((longint'(i) * 65536) / TAB_DEPTH);
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_sprite_extremes();
      test_rect_shapes();
      test_viewport_extremes();
      set_viewport(13'd640, 13'd480);
      test_output_hold_off();
      test_random_objects(100);
      wait_drained();
      if (fail_count == 0) $display("[sprite_quad_vertex_setup_unit] OK");
      else $display("[sprite_quad_vertex_setup_unit] ERROR");
      $finish;
   end

endmodule

[sprite_quad_vertex_setup_unit.f]
rtl/svs_pkg.sv
rtl/svs_sine_rom.sv
rtl/svs_mul.sv
rtl/svs_div.sv
rtl/sprite_quad_vertex_setup_unit.sv
dv/testbench.sv
